// ----- sv/rtss_pkg.sv -----
// Package for the record table with search and sort.
// Holds operation and status codes and the record type; no dependencies.
package rtss_pkg;

    localparam int NameW = 64;
    localparam int KindW = 64;
    localparam int AmtW  = 32;
    localparam int RecW  = NameW + KindW + AmtW;

    typedef enum logic [2:0] {
        FUNC_INSERT  = 3'd0,
        FUNC_REMOVE  = 3'd1,
        FUNC_LIST    = 3'd2,
        FUNC_SORT    = 3'd3,
        FUNC_SEQ     = 3'd4,
        FUNC_BIN     = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOTFOUND  = 3'd3,
        ST_SORTED    = 3'd4,
        ST_FOUND     = 3'd5,
        ST_LISTENT   = 3'd6,
        ST_LISTEMPTY = 3'd7
    } status_t;

    typedef struct packed {
        logic [NameW-1:0]        name;
        logic [KindW-1:0]        kind;
        logic signed [AmtW-1:0]  amount;
    } rec_t;

    function automatic logic [63:0] norm_text(input logic [63:0] v, input int chars);
        logic [63:0] r;
        logic        stop;
        r = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= chars || v[56-8*i +: 8] == 8'd0)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                r[56-8*i +: 8] = v[56-8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/rtss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rtss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/record_table_search_sort.sv -----
// Record table with insert, remove, list, exchange sort and two searches.
// Insert writes the record as it is accepted; sequential search reads and compares each entry in turn;
// remove searches the same way, then moves each later entry down one place; binary search probes the
// middle entry and halves the range; list emits each entry; sort compares and swaps entry pairs.
// One item is processed at a time; the next is accepted once the result is registered.
// Reset (rst_n, asynchronous) empties the table; record memory contents are not cleared.
module record_table_search_sort #(
    parameter int DEPTH      = 64,
    parameter int NAME_CHARS = 8,
    parameter int KIND_CHARS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: key_name[63:0], kind_code[127:64], amount[159:128]
    input  logic [159:0] s_tdata,
    // tuser: func[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: rec_name[63:0], rec_kind[127:64], rec_amount[159:128],
    //        compare_count[166:160], fill_count[173:167], zero pad[175:174]
    output logic [175:0] m_tdata,
    // tuser: status[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic signed [CW:0] ONE_S = 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_CHK   = 10'b0000000100,
        S_SHIFT = 10'b0000001000,
        S_SRDJ  = 10'b0000010000,
        S_SCMP  = 10'b0000100000,
        S_SWB   = 10'b0001000000,
        S_EMIT  = 10'b0010000000,
        S_WAIT  = 10'b0100000000,
        S_SRDI  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] func_reg, func_next;
    logic [63:0] key_reg, key_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic signed [CW:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [6:0] cmp_reg, cmp_next;
    rtss_pkg::rec_t reci_reg, reci_next;
    rtss_pkg::status_t st_reg, st_next;
    logic ovalid_reg, ovalid_next;
    logic [175:0] odata_reg, odata_next;
    logic [2:0] ouser_reg, ouser_next;
    logic olast_reg, olast_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    rtss_pkg::rec_t wdata, rdata;

    rtss_ram #(.WIDTH(rtss_pkg::RecW), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic [63:0] in_key;
    logic signed [CW:0] mid;
    logic out_free;
    rtss_pkg::rec_t emit_rec;
    assign in_key = rtss_pkg::norm_text(s_tdata[63:0], NAME_CHARS);
    assign mid = (lo_reg + hi_reg) >>> 1;
    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign emit_rec = (st_reg == rtss_pkg::ST_FOUND) ? reci_reg : rtss_pkg::rec_t'('0);

    assign m_tvalid = ovalid_reg;
    assign m_tdata = odata_reg;
    assign m_tuser = ouser_reg;
    assign m_tlast = olast_reg;

    function automatic logic [175:0] pack_out(input rtss_pkg::rec_t r, input logic [6:0] c,
                                              input logic [6:0] f);
        return {2'b00, f, c, r.amount, r.kind, r.name};
    endfunction

    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg;
        key_next = key_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        j_next = j_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        cmp_next = cmp_reg;
        reci_next = reci_reg;
        st_next = st_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next = odata_reg;
        ouser_next = ouser_reg;
        olast_next = olast_reg;
        we = 1'b0;
        waddr = i_reg[AW-1:0];
        wdata = rdata;
        raddr = i_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next = s_tuser;
                    key_next = in_key;
                    i_next = '0;
                    cmp_next = '0;
                    lo_next = '0;
                    hi_next = $signed({1'b0, cnt_reg}) - ONE_S;
                    case (s_tuser)
                        rtss_pkg::FUNC_INSERT:
                        begin
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                st_next = rtss_pkg::ST_FULL;
                            end
                            else
                            begin
                                we = 1'b1;
                                waddr = cnt_reg[AW-1:0];
                                wdata.name = in_key;
                                wdata.kind = rtss_pkg::norm_text(s_tdata[127:64], KIND_CHARS);
                                wdata.amount = s_tdata[159:128];
                                cnt_next = cnt_reg + 1'b1;
                                st_next = rtss_pkg::ST_INSERTED;
                            end
                            state_next = S_EMIT;
                        end
                        rtss_pkg::FUNC_SORT:
                        begin
                            st_next = rtss_pkg::ST_SORTED;
                            state_next = (cnt_reg > 1) ? S_SRDI : S_EMIT;
                        end
                        rtss_pkg::FUNC_LIST:
                        begin
                            st_next = rtss_pkg::ST_LISTEMPTY;
                            state_next = (cnt_reg == '0) ? S_EMIT : S_RD;
                        end
                        rtss_pkg::FUNC_REMOVE, rtss_pkg::FUNC_SEQ, rtss_pkg::FUNC_BIN:
                        begin
                            st_next = rtss_pkg::ST_NOTFOUND;
                            state_next = (cnt_reg == '0) ? S_EMIT : S_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                if (func_reg == rtss_pkg::FUNC_BIN)
                begin
                    raddr = mid[AW-1:0];
                end
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (func_reg == rtss_pkg::FUNC_LIST)
                begin
                    if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        ouser_next = rtss_pkg::ST_LISTENT;
                        odata_next = pack_out(rdata, 7'd0, 7'(cnt_reg));
                        olast_next = (i_reg == cnt_reg - 1'b1);
                        i_next = i_reg + 1'b1;
                        state_next = (i_reg == cnt_reg - 1'b1) ? S_IDLE : S_RD;
                    end
                    else
                    begin
                        reci_next = rdata;
                        state_next = S_WAIT;
                    end
                end
                else if (func_reg == rtss_pkg::FUNC_BIN)
                begin
                    cmp_next = cmp_reg + 1'b1;
                    if (key_reg == rdata.name)
                    begin
                        reci_next = rdata;
                        st_next = rtss_pkg::ST_FOUND;
                        state_next = S_EMIT;
                    end
                    else if (key_reg < rdata.name)
                    begin
                        hi_next = mid - ONE_S;
                        state_next = (lo_reg <= mid - ONE_S) ? S_RD : S_EMIT;
                    end
                    else
                    begin
                        lo_next = mid + ONE_S;
                        state_next = (mid + ONE_S <= hi_reg) ? S_RD : S_EMIT;
                    end
                end
                else
                begin
                    if (func_reg == rtss_pkg::FUNC_SEQ)
                    begin
                        cmp_next = cmp_reg + 1'b1;
                    end
                    if (rdata.name == key_reg)
                    begin
                        if (func_reg == rtss_pkg::FUNC_REMOVE)
                        begin
                            st_next = rtss_pkg::ST_REMOVED;
                            j_next = i_reg + 1'b1;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            reci_next = rdata;
                            st_next = rtss_pkg::ST_FOUND;
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = (i_reg == cnt_reg - 1'b1) ? S_EMIT : S_RD;
                    end
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ouser_next = rtss_pkg::ST_LISTENT;
                    odata_next = pack_out(reci_reg, 7'd0, 7'(cnt_reg));
                    olast_next = (i_reg == cnt_reg - 1'b1);
                    i_next = i_reg + 1'b1;
                    state_next = (i_reg == cnt_reg - 1'b1) ? S_IDLE : S_RD;
                end
            end
            S_SHIFT:
            begin
                // j_reg addresses the entry being moved down to j_reg - 1.
                if (j_reg >= cnt_reg)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    raddr = j_reg[AW-1:0];
                    state_next = S_SWB;
                end
            end
            S_SRDI:
            begin
                raddr = i_reg[AW-1:0];
                j_next = i_reg + 1'b1;
                state_next = S_SRDJ;
            end
            S_SRDJ:
            begin
                reci_next = rdata;
                raddr = j_reg[AW-1:0];
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (reci_reg.name > rdata.name)
                begin
                    we = 1'b1;
                    waddr = j_reg[AW-1:0];
                    wdata = reci_reg;
                    reci_next = rdata;
                end
                state_next = S_SWB;
            end
            S_SWB:
            begin
                if (func_reg == rtss_pkg::FUNC_REMOVE)
                begin
                    we = 1'b1;
                    waddr = AW'(j_reg - 1'b1);
                    wdata = rdata;
                    j_next = j_reg + 1'b1;
                    state_next = S_SHIFT;
                end
                else if (j_reg == cnt_reg - 1'b1)
                begin
                    we = 1'b1;
                    waddr = i_reg[AW-1:0];
                    wdata = reci_reg;
                    i_next = i_reg + 1'b1;
                    state_next = (i_reg + 2'd2 >= cnt_reg) ? S_EMIT : S_SRDI;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    raddr = AW'(j_reg + 1'b1);
                    state_next = S_SCMP;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    olast_next = 1'b1;
                    ouser_next = st_reg;
                    odata_next = pack_out(emit_rec, cmp_reg, 7'(cnt_reg));
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        key_reg <= key_next;
        i_reg <= i_next;
        j_reg <= j_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        cmp_reg <= cmp_next;
        reci_reg <= reci_next;
        st_reg <= st_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
        olast_reg <= olast_next;
    end

endmodule

// ----- sv/rtss_checker.sv -----
// Port-level checker for the record table, bound to the top level.
// Depends on rtss_pkg and the top level's ports.
module rtss_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [175:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[173:167] <= 7'd64)
        else $error("fill count out of range");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != rtss_pkg::ST_LISTENT) |-> m_tlast)
        else $error("non-list result without last");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

bind record_table_search_sort rtss_checker u_rtss_checker (.*);
